// File: design/raf_pkg.sv
// Shared types and constants for the radial falloff alpha generator.
package raf_pkg;

    typedef struct packed {
        logic valid;
        logic ovf;
    } raf_ctl_t;

    localparam int CFG_W    = 11;
    localparam int PIX_W    = 10;
    localparam int ALPHA_W  = 8;
    localparam int QUOT_W   = 32;
    localparam int ROOT_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int UNIT_W   = FRAC_W + 1;
    localparam int SIZE_RST = 256;

endpackage

// File: design/raf_front.sv
// Front stages: saturate size, form offsets, squared distance and denominator.
module raf_front #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [raf_pkg::PIX_W-1:0]     pixel_x,
    input  logic [raf_pkg::PIX_W-1:0]     pixel_y,
    input  logic [raf_pkg::CFG_W-1:0]     size_cfg,
    output raf_pkg::raf_ctl_t             ctl,
    output logic [2*$clog2(MAX_SIZE+1):0] rem,
    output logic [2*$clog2(MAX_SIZE+1):0] den
);
    import raf_pkg::*;

    localparam int SW  = $clog2(MAX_SIZE + 1);
    localparam int AW  = (SW > PIX_W + 1) ? SW : PIX_W + 1;
    localparam int NW  = 2 * SW + 1;
    localparam int DW2 = 2 * AW + 1;

    logic [AW-1:0]    size_ext;
    logic [AW-1:0]    size_sat;
    logic [AW-1:0]    ax2;
    logic [AW-1:0]    ay2;
    logic [AW-1:0]    ax_next;
    logic [AW-1:0]    ay_next;

    raf_ctl_t         c1_reg;
    logic [AW-1:0]    ax_reg;
    logic [AW-1:0]    ay_reg;
    logic [SW-1:0]    s_reg;

    raf_ctl_t         c2_reg;
    logic [2*AW-1:0]  axx_reg;
    logic [2*AW-1:0]  ayy_reg;
    logic [NW-1:0]    den2_reg;

    raf_ctl_t         c3_reg;
    logic [DW2-1:0]   d2_reg;
    logic [NW-1:0]    den3_reg;

    raf_ctl_t         c4_reg;
    logic [NW-1:0]    rem_reg;
    logic [NW-1:0]    den4_reg;

    logic [2*SW-1:0]  ss;

    always_comb
    begin
        size_ext = AW'(size_cfg);
        size_sat = (size_ext > AW'(MAX_SIZE)) ? AW'(MAX_SIZE) : size_ext;
        ax2      = AW'({pixel_x, 1'b0});
        ay2      = AW'({pixel_y, 1'b0});
        ax_next  = (ax2 >= size_sat) ? ax2 - size_sat : size_sat - ax2;
        ay_next  = (ay2 >= size_sat) ? ay2 - size_sat : size_sat - ay2;
        ss       = s_reg * s_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else
        begin
            c1_reg.valid <= in_valid;
            c1_reg.ovf   <= (size_sat == '0);
            c2_reg       <= c1_reg;
            c3_reg       <= c2_reg;
            c4_reg.valid <= c3_reg.valid;
            // ratio at or beyond 1.0 clamps alpha to zero
            c4_reg.ovf   <= c3_reg.ovf || (d2_reg >= DW2'(den3_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        s_reg    <= SW'(size_sat);
        axx_reg  <= ax_reg * ax_reg;
        ayy_reg  <= ay_reg * ay_reg;
        den2_reg <= {ss, 1'b0};
        d2_reg   <= DW2'(axx_reg) + DW2'(ayy_reg);
        den3_reg <= den2_reg;
        rem_reg  <= NW'(d2_reg);
        den4_reg <= den3_reg;
    end

    assign ctl = c4_reg;
    assign rem = rem_reg;
    assign den = den4_reg;

endmodule

// File: design/raf_div.sv
// Pipelined restoring divider: one quotient bit per stage.
module raf_div #(
    parameter int NW = 23
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  raf_pkg::raf_ctl_t             in_ctl,
    input  logic [NW-1:0]                 in_rem,
    input  logic [NW-1:0]                 in_den,
    output raf_pkg::raf_ctl_t             out_ctl,
    output logic [raf_pkg::QUOT_W-1:0]    quot
);
    import raf_pkg::*;

    raf_ctl_t          ctl_reg  [0:QUOT_W];
    logic [NW-1:0]     rem_reg  [0:QUOT_W];
    logic [NW-1:0]     den_reg  [0:QUOT_W];
    logic [QUOT_W-1:0] quot_reg [0:QUOT_W];

    assign ctl_reg[0]  = in_ctl;
    assign rem_reg[0]  = in_rem;
    assign den_reg[0]  = in_den;
    assign quot_reg[0] = '0;

    for (genvar i = 0; i < QUOT_W; i++)
    begin : g_stage
        logic [NW:0] r2;
        logic        take;

        always_comb
        begin
            r2   = {rem_reg[i], 1'b0};
            take = (r2 >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i+1] <= '0;
            else
                ctl_reg[i+1] <= ctl_reg[i];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= take ? NW'(r2 - {1'b0, den_reg[i]}) : NW'(r2);
            den_reg[i+1]  <= den_reg[i];
            quot_reg[i+1] <= {quot_reg[i][QUOT_W-2:0], take};
        end
    end

    assign out_ctl = ctl_reg[QUOT_W];
    assign quot    = quot_reg[QUOT_W];

endmodule

// File: design/raf_sqrt.sv
// Pipelined integer square root: one root bit per stage.
module raf_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  raf_pkg::raf_ctl_t             in_ctl,
    input  logic [raf_pkg::QUOT_W-1:0]    val,
    output raf_pkg::raf_ctl_t             out_ctl,
    output logic [raf_pkg::ROOT_W-1:0]    root
);
    import raf_pkg::*;

    localparam int RW = ROOT_W + 2;

    raf_ctl_t          ctl_reg  [0:ROOT_W];
    logic [QUOT_W-1:0] val_reg  [0:ROOT_W];
    logic [RW-1:0]     rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];

    assign ctl_reg[0]  = in_ctl;
    assign val_reg[0]  = val;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic [RW+1:0] sh;
        logic [RW+1:0] trial;
        logic          take;

        always_comb
        begin
            sh    = {rem_reg[i], val_reg[i][QUOT_W-1:QUOT_W-2]};
            trial = (RW+2)'({root_reg[i], 2'b01});
            take  = (sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i+1] <= '0;
            else
                ctl_reg[i+1] <= ctl_reg[i];
        end

        always_ff @(posedge clk)
        begin
            val_reg[i+1]  <= {val_reg[i][QUOT_W-3:0], 2'b00};
            rem_reg[i+1]  <= take ? RW'(sh - trial) : RW'(sh);
            root_reg[i+1] <= {root_reg[i][ROOT_W-2:0], take};
        end
    end

    assign out_ctl = ctl_reg[ROOT_W];
    assign root    = root_reg[ROOT_W];

endmodule

// File: design/raf_power.sv
// Falloff stages: complement, three squarings and scale to an alpha byte.
module raf_power (
    input  logic                          clk,
    input  logic                          rst_n,
    input  raf_pkg::raf_ctl_t             in_ctl,
    input  logic [raf_pkg::ROOT_W-1:0]    root,
    output logic                          out_valid,
    output logic [raf_pkg::ALPHA_W-1:0]   alpha
);
    import raf_pkg::*;

    localparam int NSQ = 3;
    localparam logic [UNIT_W-1:0] ONE = UNIT_W'(1) << FRAC_W;
    localparam logic [ALPHA_W-1:0] SCALE = '1;

    logic [NSQ+1:0]         v_reg;
    logic [UNIT_W-1:0]      q_reg [0:NSQ];
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [UNIT_W+ALPHA_W-1:0] scaled;

    assign scaled = q_reg[NSQ] * SCALE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[NSQ:0], in_ctl.valid};
    end

    always_ff @(posedge clk)
    begin
        q_reg[0]  <= in_ctl.ovf ? '0 : ONE - UNIT_W'(root);
        alpha_reg <= scaled[FRAC_W +: ALPHA_W];
    end

    for (genvar i = 0; i < NSQ; i++)
    begin : g_sq
        logic [2*UNIT_W-1:0] prod;

        assign prod = q_reg[i] * q_reg[i];

        always_ff @(posedge clk)
        begin
            // truncate back to Q1.16
            q_reg[i+1] <= prod[FRAC_W +: UNIT_W];
        end
    end

    assign out_valid = v_reg[NSQ+1];
    assign alpha     = alpha_reg;

endmodule

// File: design/radial_falloff_alpha_generator.sv
// Throughput is one pixel per clock. The pipeline has 4 front stages for offsets and
// squares, 32 divider stages for the squared ratio, 16 square-root stages and 5 falloff
// stages. busy is always low: a request is taken whenever start is high, and
// each result appears on alpha_value for exactly one cycle with done high; the receiver
// cannot stall, so results must be captured when done is seen. Write sprite_size only
// while no request is in flight.
module radial_falloff_alpha_generator #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [raf_pkg::PIX_W-1:0]     pixel_x,
    input  logic [raf_pkg::PIX_W-1:0]     pixel_y,
    input  logic                          cfg_write,
    input  logic [raf_pkg::CFG_W-1:0]     cfg_data,
    output logic                          done,
    output logic [raf_pkg::ALPHA_W-1:0]   alpha_value
);
    import raf_pkg::*;

    localparam int SW = $clog2(MAX_SIZE + 1);
    localparam int NW = 2 * SW + 1;

    logic [CFG_W-1:0]  size_reg;
    raf_ctl_t          front_ctl;
    logic [NW-1:0]     front_rem;
    logic [NW-1:0]     front_den;
    raf_ctl_t          div_ctl;
    logic [QUOT_W-1:0] div_quot;
    raf_ctl_t          sqrt_ctl;
    logic [ROOT_W-1:0] sqrt_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= CFG_W'(SIZE_RST);
        else if (cfg_write)
            size_reg <= cfg_data;
    end

    assign busy = 1'b0;

    raf_front #(.MAX_SIZE(MAX_SIZE)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .size_cfg (size_reg),
        .ctl      (front_ctl),
        .rem      (front_rem),
        .den      (front_den)
    );

    raf_div #(.NW(NW)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (front_ctl),
        .in_rem  (front_rem),
        .in_den  (front_den),
        .out_ctl (div_ctl),
        .quot    (div_quot)
    );

    raf_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (div_ctl),
        .val     (div_quot),
        .out_ctl (sqrt_ctl),
        .root    (sqrt_root)
    );

    raf_power u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (sqrt_ctl),
        .root      (sqrt_root),
        .out_valid (done),
        .alpha     (alpha_value)
    );

endmodule
